### hw/rtl/bsfs_pkg.sv
// ============================================================================
// bsfs_pkg
// Shared types, widths and constants for the burst sharpest-frame selector.
// ============================================================================
package bsfs_pkg;

   // Frame and burst limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_BURST  = 16;

   // Field and datapath widths
   localparam int COL_W      = 11;
   localparam int DIM_W      = 12;
   localparam int BURST_W    = 5;
   localparam int IDX_W      = 4;
   localparam int PIX_W      = 8;
   localparam int SCORE_W    = 28;
   localparam int SUM_W      = 34;
   localparam int SQSUM_W    = 43;
   localparam int LAP_W      = 11;
   localparam int LAP_FULL_W = 13;
   localparam int SQ_W       = 20;
   localparam int N_W        = 23;
   localparam int MAG_W      = 34;
   localparam int HALF_W     = 17;
   localparam int OPND_W     = 24;
   localparam int PROD_W     = 48;
   localparam int WIDE_W     = 68;
   localparam int DEN_W      = 46;
   localparam int NUM_W      = 76;
   localparam int FRAC_W     = 8;
   localparam int GSUM_W     = 23;
   localparam int SEL_W      = 2;
   localparam int CNT_W      = 11;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_INPUT  = 2'd3;

   localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 12'd1280;
   localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 12'd720;
   localparam logic [BURST_W-1:0] RST_BURST_LENGTH = 5'd5;
   localparam logic               RST_COLOR_INPUT  = 1'b1;

   // Fixed-point BT.601 gray weights
   localparam logic [GSUM_W-1:0] GRAY_WB    = 23'd1868;
   localparam logic [GSUM_W-1:0] GRAY_WG    = 23'd9617;
   localparam logic [GSUM_W-1:0] GRAY_WR    = 23'd4899;
   localparam logic [GSUM_W-1:0] GRAY_RND   = 23'd8192;
   localparam int                GRAY_SHIFT = 14;

   // Sequencer step counts
   localparam logic [CNT_W-1:0] DRAIN_LAST = 11'd4;
   localparam logic [CNT_W-1:0] MUL_LAST   = 11'd7;
   localparam logic [CNT_W-1:0] DIV_LAST   = 11'(SCORE_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_MUL,
      ST_SUB,
      ST_LOAD,
      ST_DIV,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_N,
      MOP_SS_LL,
      MOP_SS_LH,
      MOP_SS_HH,
      MOP_NQ_LO,
      MOP_NQ_HI,
      MOP_NN
   } mul_op_type;

   // Effective configuration handed to the datapath
   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [BURST_W-1:0] burst;
      logic               color;
   } cfg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic               restart;
      logic               wr_en;
      logic [SEL_W-1:0]   wr_bank;
      logic [COL_W-1:0]   wr_addr;
      logic               rd_en;
      logic [COL_W-1:0]   rd_addr;
      logic               rd_last;
      logic [SEL_W-1:0]   up_sel;
      logic [SEL_W-1:0]   mid_sel;
      logic [SEL_W-1:0]   dn_sel;
      mul_op_type         mul_op;
      logic               sub_en;
      logic               load_en;
      logic               div_en;
      logic               finish;
   } cmd_type;

endpackage

### hw/rtl/burst_sharpest_frame_select_top.sv
// ============================================================================
// burst_sharpest_frame_select_top
// Scores each frame by the variance of its Laplacian and picks the sharpest
// frame of a burst.
// ============================================================================
// Pixels are taken one per cycle within a row. At the end of every row after
// the first, input stalls for a sweep over the stored rows that reads one
// column at a time through the single read port of each row buffer.
// At the end of a frame a second sweep handles the bottom border, then the
// shared 24x24 multiplies, a subtract step, a load step, the bit-serial
// division and the best-frame update follow before the result is offered;
// input resumes once the result is transferred. Each frame gives exactly one
// result. Any configuration write restarts the frame and the burst.
module burst_sharpest_frame_select_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bsfs_pkg::PIX_W-1:0]       req_blue_or_gray,
   input  logic [bsfs_pkg::PIX_W-1:0]       req_green,
   input  logic [bsfs_pkg::PIX_W-1:0]       req_red,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bsfs_pkg::SCORE_W-1:0]     rsp_frame_score,
   output logic [bsfs_pkg::IDX_W-1:0]       rsp_frame_number,
   output logic                             rsp_burst_done,
   output logic [bsfs_pkg::IDX_W-1:0]       rsp_sharpest_frame,
   output logic [bsfs_pkg::SCORE_W-1:0]     rsp_best_score,
   input  logic                             csr_we,
   input  logic [bsfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bsfs_pkg::cfg_type cfg;
   bsfs_pkg::cmd_type cmd;

   // Sequencer and configuration
   bsfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cmd       (cmd)
   );

   // Pixel path, arithmetic and result register
   bsfs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .req_blue_or_gray   (req_blue_or_gray),
      .req_green          (req_green),
      .req_red            (req_red),
      .rsp_frame_score    (rsp_frame_score),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_burst_done     (rsp_burst_done),
      .rsp_sharpest_frame (rsp_sharpest_frame),
      .rsp_best_score     (rsp_best_score)
   );

endmodule

### hw/rtl/bsfs_ctrl.sv
// ============================================================================
// bsfs_ctrl
// Configuration registers, raster position tracking, row-buffer roles and the
// sequencer that drives row sweeps, the frame-end multiply and the division.
// ============================================================================
module bsfs_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              csr_we,
   input  logic [bsfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsfs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bsfs_pkg::cfg_type                 cfg,
   output bsfs_pkg::cmd_type                 cmd
);

   bsfs_pkg::state_type state_ff, state_in;

   logic [bsfs_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [bsfs_pkg::COL_W-1:0]   col_ff, col_in;
   logic [bsfs_pkg::COL_W-1:0]   row_ff, row_in;
   logic [bsfs_pkg::SEL_W-1:0]   u_sel_ff, u_sel_in;
   logic [bsfs_pkg::SEL_W-1:0]   m_sel_ff, m_sel_in;
   logic [bsfs_pkg::SEL_W-1:0]   c_sel_ff, c_sel_in;
   logic [bsfs_pkg::SEL_W-1:0]   up_sel_ff, up_sel_in;
   logic [bsfs_pkg::SEL_W-1:0]   mid_sel_ff, mid_sel_in;
   logic [bsfs_pkg::SEL_W-1:0]   dn_sel_ff, dn_sel_in;
   logic                         last_row_ff, last_row_in;
   logic                         second_ff, second_in;

   logic [bsfs_pkg::DIM_W-1:0]   fw_ff;
   logic [bsfs_pkg::DIM_W-1:0]   fh_ff;
   logic [bsfs_pkg::BURST_W-1:0] bl_ff;
   logic                         ci_ff;

   logic [bsfs_pkg::DIM_W-1:0]   w_eff;
   logic [bsfs_pkg::DIM_W-1:0]   h_eff;
   logic [bsfs_pkg::BURST_W-1:0] b_eff;
   logic                         accept;
   logic                         col_end;
   logic                         row_last;
   logic                         sweep_end;
   logic                         drain_end;

   // Clamp the registers to the supported ranges
   always_comb begin
      w_eff = fw_ff;
      if (fw_ff < bsfs_pkg::DIM_W'(2)) begin
         w_eff = bsfs_pkg::DIM_W'(2);
      end else if (fw_ff > bsfs_pkg::DIM_W'(bsfs_pkg::MAX_WIDTH)) begin
         w_eff = bsfs_pkg::DIM_W'(bsfs_pkg::MAX_WIDTH);
      end
      h_eff = fh_ff;
      if (fh_ff < bsfs_pkg::DIM_W'(2)) begin
         h_eff = bsfs_pkg::DIM_W'(2);
      end else if (fh_ff > bsfs_pkg::DIM_W'(bsfs_pkg::MAX_HEIGHT)) begin
         h_eff = bsfs_pkg::DIM_W'(bsfs_pkg::MAX_HEIGHT);
      end
      b_eff = bl_ff;
      if (bl_ff < bsfs_pkg::BURST_W'(1)) begin
         b_eff = bsfs_pkg::BURST_W'(1);
      end else if (bl_ff > bsfs_pkg::BURST_W'(bsfs_pkg::MAX_BURST)) begin
         b_eff = bsfs_pkg::BURST_W'(bsfs_pkg::MAX_BURST);
      end
   end

   assign cfg.width  = w_eff;
   assign cfg.height = h_eff;
   assign cfg.burst  = b_eff;
   assign cfg.color  = ci_ff;

   assign accept    = req_valid && (state_ff == bsfs_pkg::ST_IDLE);
   assign col_end   = ({1'b0, col_ff} + 1'b1) == w_eff;
   assign row_last  = ({1'b0, row_ff} + 1'b1) == h_eff;
   assign sweep_end = cnt_ff == bsfs_pkg::CNT_W'(w_eff - 1'b1);
   assign drain_end = cnt_ff == bsfs_pkg::DRAIN_LAST;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= bsfs_pkg::RST_FRAME_WIDTH;
         fh_ff <= bsfs_pkg::RST_FRAME_HEIGHT;
         bl_ff <= bsfs_pkg::RST_BURST_LENGTH;
         ci_ff <= bsfs_pkg::RST_COLOR_INPUT;
      end else if (csr_we) begin
         case (csr_index)
            bsfs_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[bsfs_pkg::DIM_W-1:0];
            bsfs_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_wdata[bsfs_pkg::DIM_W-1:0];
            bsfs_pkg::CSR_BURST_LENGTH: bl_ff <= csr_wdata[bsfs_pkg::BURST_W-1:0];
            bsfs_pkg::CSR_COLOR_INPUT:  ci_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsfs_pkg::ST_IDLE: begin
            if (accept && col_end && (row_ff != '0)) begin
               state_in = bsfs_pkg::ST_SWEEP;
            end
         end
         bsfs_pkg::ST_SWEEP: begin
            if (sweep_end) begin
               state_in = bsfs_pkg::ST_DRAIN;
            end
         end
         bsfs_pkg::ST_DRAIN: begin
            if (drain_end) begin
               if (second_ff) begin
                  state_in = bsfs_pkg::ST_MUL;
               end else if (last_row_ff) begin
                  state_in = bsfs_pkg::ST_SWEEP;
               end else begin
                  state_in = bsfs_pkg::ST_IDLE;
               end
            end
         end
         bsfs_pkg::ST_MUL: begin
            if (cnt_ff == bsfs_pkg::MUL_LAST) begin
               state_in = bsfs_pkg::ST_SUB;
            end
         end
         bsfs_pkg::ST_SUB:    state_in = bsfs_pkg::ST_LOAD;
         bsfs_pkg::ST_LOAD:   state_in = bsfs_pkg::ST_DIV;
         bsfs_pkg::ST_DIV: begin
            if (cnt_ff == bsfs_pkg::DIV_LAST) begin
               state_in = bsfs_pkg::ST_FINISH;
            end
         end
         bsfs_pkg::ST_FINISH: state_in = bsfs_pkg::ST_RESP;
         bsfs_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = bsfs_pkg::ST_IDLE;
            end
         end
         default: state_in = bsfs_pkg::ST_IDLE;
      endcase
      if (csr_we) begin
         state_in = bsfs_pkg::ST_IDLE;
      end
   end

   // Position, buffer roles and sweep selection
   always_comb begin
      cnt_in      = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
      col_in      = col_ff;
      row_in      = row_ff;
      u_sel_in    = u_sel_ff;
      m_sel_in    = m_sel_ff;
      c_sel_in    = c_sel_ff;
      up_sel_in   = up_sel_ff;
      mid_sel_in  = mid_sel_ff;
      dn_sel_in   = dn_sel_ff;
      last_row_in = last_row_ff;
      second_in   = second_ff;
      // advance the raster position on each pixel transfer
      if (accept) begin
         col_in = col_end ? '0 : col_ff + 1'b1;
         if (col_end) begin
            if (row_ff == '0) begin
               u_sel_in = m_sel_ff;
               m_sel_in = c_sel_ff;
               c_sel_in = u_sel_ff;
               row_in   = row_ff + 1'b1;
            end else begin
               // top row reflects its upper neighbor to the row below
               up_sel_in   = (row_ff == bsfs_pkg::COL_W'(1)) ? c_sel_ff : u_sel_ff;
               mid_sel_in  = m_sel_ff;
               dn_sel_in   = c_sel_ff;
               last_row_in = row_last;
               second_in   = 1'b0;
            end
         end
      end
      // rotate the row buffers once the sweep has drained
      if ((state_ff == bsfs_pkg::ST_DRAIN) && drain_end) begin
         if (second_ff) begin
            second_in = 1'b0;
         end else begin
            u_sel_in = m_sel_ff;
            m_sel_in = c_sel_ff;
            c_sel_in = u_sel_ff;
            row_in   = last_row_ff ? '0 : row_ff + 1'b1;
            if (last_row_ff) begin
               // bottom row reflects its lower neighbor to the row above
               second_in  = 1'b1;
               up_sel_in  = m_sel_ff;
               mid_sel_in = c_sel_ff;
               dn_sel_in  = m_sel_ff;
            end
         end
      end
      if (csr_we) begin
         col_in      = '0;
         row_in      = '0;
         last_row_in = 1'b0;
         second_in   = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bsfs_pkg::ST_IDLE;
         cnt_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         u_sel_ff    <= 2'd0;
         m_sel_ff    <= 2'd1;
         c_sel_ff    <= 2'd2;
         up_sel_ff   <= 2'd0;
         mid_sel_ff  <= 2'd1;
         dn_sel_ff   <= 2'd2;
         last_row_ff <= 1'b0;
         second_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         u_sel_ff    <= u_sel_in;
         m_sel_ff    <= m_sel_in;
         c_sel_ff    <= c_sel_in;
         up_sel_ff   <= up_sel_in;
         mid_sel_ff  <= mid_sel_in;
         dn_sel_ff   <= dn_sel_in;
         last_row_ff <= last_row_in;
         second_ff   <= second_in;
      end
   end

   // Outputs and datapath commands
   always_comb begin
      req_ready   = state_ff == bsfs_pkg::ST_IDLE;
      rsp_valid   = state_ff == bsfs_pkg::ST_RESP;
      cmd.restart = csr_we;
      cmd.wr_en   = accept;
      cmd.wr_bank = c_sel_ff;
      cmd.wr_addr = col_ff;
      cmd.rd_en   = state_ff == bsfs_pkg::ST_SWEEP;
      cmd.rd_addr = cnt_ff;
      cmd.rd_last = (state_ff == bsfs_pkg::ST_SWEEP) && sweep_end;
      cmd.up_sel  = up_sel_ff;
      cmd.mid_sel = mid_sel_ff;
      cmd.dn_sel  = dn_sel_ff;
      cmd.mul_op  = bsfs_pkg::MOP_NONE;
      if (state_ff == bsfs_pkg::ST_MUL) begin
         case (cnt_ff[2:0])
            3'd0:    cmd.mul_op = bsfs_pkg::MOP_N;
            3'd1:    cmd.mul_op = bsfs_pkg::MOP_SS_LL;
            3'd2:    cmd.mul_op = bsfs_pkg::MOP_SS_LH;
            3'd3:    cmd.mul_op = bsfs_pkg::MOP_SS_HH;
            3'd4:    cmd.mul_op = bsfs_pkg::MOP_NQ_LO;
            3'd5:    cmd.mul_op = bsfs_pkg::MOP_NQ_HI;
            3'd6:    cmd.mul_op = bsfs_pkg::MOP_NN;
            default: cmd.mul_op = bsfs_pkg::MOP_NONE;
         endcase
      end
      cmd.sub_en  = state_ff == bsfs_pkg::ST_SUB;
      cmd.load_en = state_ff == bsfs_pkg::ST_LOAD;
      cmd.div_en  = state_ff == bsfs_pkg::ST_DIV;
      cmd.finish  = state_ff == bsfs_pkg::ST_FINISH;
   end

endmodule

### hw/rtl/bsfs_datapath.sv
// ============================================================================
// bsfs_datapath
// Gray conversion, three rotating row buffers, Laplacian window and sums,
// the shared frame-end multiplier, a bit-serial divider and burst tracking.
// ============================================================================
module bsfs_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  bsfs_pkg::cfg_type                cfg,
   input  bsfs_pkg::cmd_type                cmd,
   input  logic [bsfs_pkg::PIX_W-1:0]       req_blue_or_gray,
   input  logic [bsfs_pkg::PIX_W-1:0]       req_green,
   input  logic [bsfs_pkg::PIX_W-1:0]       req_red,
   output logic [bsfs_pkg::SCORE_W-1:0]     rsp_frame_score,
   output logic [bsfs_pkg::IDX_W-1:0]       rsp_frame_number,
   output logic                             rsp_burst_done,
   output logic [bsfs_pkg::IDX_W-1:0]       rsp_sharpest_frame,
   output logic [bsfs_pkg::SCORE_W-1:0]     rsp_best_score
);

   // Row buffers
   logic [bsfs_pkg::PIX_W-1:0] bank0 [bsfs_pkg::MAX_WIDTH];
   logic [bsfs_pkg::PIX_W-1:0] bank1 [bsfs_pkg::MAX_WIDTH];
   logic [bsfs_pkg::PIX_W-1:0] bank2 [bsfs_pkg::MAX_WIDTH];

   logic [bsfs_pkg::GSUM_W-1:0] gsum;
   logic [bsfs_pkg::PIX_W-1:0]  gray;

   logic [bsfs_pkg::PIX_W-1:0] q0_ff, q1_ff, q2_ff;
   logic                       d_v_ff;
   logic                       d_last_ff;
   logic [bsfs_pkg::COL_W-1:0] d_addr_ff;
   logic                       fl_v_ff;
   logic [bsfs_pkg::PIX_W-1:0] q_up, q_mid, q_dn;
   logic [bsfs_pkg::PIX_W-1:0] l_ff, c_ff, u_ff, dn_ff;
   logic [bsfs_pkg::PIX_W-1:0] ev_left, ev_right;
   logic                       ev;

   logic signed [bsfs_pkg::LAP_FULL_W-1:0] lap_full;
   logic signed [bsfs_pkg::LAP_W-1:0]      lap_ff;
   logic                                   lap_v_ff;
   logic signed [2*bsfs_pkg::LAP_W-1:0]    lap_sq;
   logic [bsfs_pkg::SQ_W-1:0]              sq_ff;
   logic                                   sq_v_ff;
   logic signed [bsfs_pkg::SUM_W-1:0]      sum_ff;
   logic [bsfs_pkg::SQSUM_W-1:0]           sqsum_ff;

   logic [bsfs_pkg::MAG_W-1:0]  mag_ff;
   logic [bsfs_pkg::N_W-1:0]    n_ff;
   logic [bsfs_pkg::OPND_W-1:0] mul_a, mul_b;
   logic [bsfs_pkg::PROD_W-1:0] prod_ff;
   bsfs_pkg::mul_op_type        prod_op_ff;
   logic [bsfs_pkg::WIDE_W-1:0] prod_sh;
   logic [bsfs_pkg::WIDE_W-1:0] nq_ff, ss_ff, d_ff;
   logic [bsfs_pkg::DEN_W-1:0]  den_ff;

   logic [bsfs_pkg::NUM_W-1:0]    num;
   logic [bsfs_pkg::DEN_W-1:0]    rem_ff;
   logic [bsfs_pkg::SCORE_W-1:0]  qs_ff;
   logic [bsfs_pkg::DEN_W:0]      trial;
   logic                          ge;

   logic [bsfs_pkg::IDX_W-1:0]   fib_ff;
   logic [bsfs_pkg::WIDE_W-1:0]  best_metric_ff;
   logic [bsfs_pkg::IDX_W-1:0]   best_index_ff;
   logic [bsfs_pkg::SCORE_W-1:0] best_var_ff;
   logic                         take;
   logic                         done;
   logic [bsfs_pkg::IDX_W-1:0]   new_idx;
   logic [bsfs_pkg::SCORE_W-1:0] new_var;

   // Convert the incoming pixel to gray
   assign gsum = bsfs_pkg::GRAY_WB * bsfs_pkg::GSUM_W'(req_blue_or_gray)
               + bsfs_pkg::GRAY_WG * bsfs_pkg::GSUM_W'(req_green)
               + bsfs_pkg::GRAY_WR * bsfs_pkg::GSUM_W'(req_red)
               + bsfs_pkg::GRAY_RND;
   assign gray = cfg.color ? gsum[bsfs_pkg::GRAY_SHIFT +: bsfs_pkg::PIX_W] : req_blue_or_gray;

   // Write the pixel transfer into the current row, read all rows during a sweep
   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_bank == 2'd0)) begin
         bank0[cmd.wr_addr] <= gray;
      end
      if (cmd.wr_en && (cmd.wr_bank == 2'd1)) begin
         bank1[cmd.wr_addr] <= gray;
      end
      if (cmd.wr_en && (cmd.wr_bank == 2'd2)) begin
         bank2[cmd.wr_addr] <= gray;
      end
      if (cmd.rd_en) begin
         q0_ff <= bank0[cmd.rd_addr];
         q1_ff <= bank1[cmd.rd_addr];
         q2_ff <= bank2[cmd.rd_addr];
      end
      d_addr_ff <= cmd.rd_addr;
      d_last_ff <= cmd.rd_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff  <= 1'b0;
         fl_v_ff <= 1'b0;
      end else begin
         d_v_ff  <= cmd.rd_en;
         fl_v_ff <= d_v_ff && d_last_ff;
      end
   end

   // Route the three buffers to their window roles
   always_comb begin
      case (cmd.up_sel)
         2'd1:    q_up = q1_ff;
         2'd2:    q_up = q2_ff;
         default: q_up = q0_ff;
      endcase
      case (cmd.mid_sel)
         2'd1:    q_mid = q1_ff;
         2'd2:    q_mid = q2_ff;
         default: q_mid = q0_ff;
      endcase
      case (cmd.dn_sel)
         2'd1:    q_dn = q1_ff;
         2'd2:    q_dn = q2_ff;
         default: q_dn = q0_ff;
      endcase
   end

   // Shift the window along the middle row
   always_ff @(posedge clock) begin
      if (d_v_ff) begin
         l_ff  <= c_ff;
         c_ff  <= q_mid;
         u_ff  <= q_up;
         dn_ff <= q_dn;
      end
   end

   // Laplacian of the previous column; reflect at the left and right edges
   always_comb begin
      ev       = (d_v_ff && (d_addr_ff != '0)) || fl_v_ff;
      ev_left  = (!fl_v_ff && (d_addr_ff == bsfs_pkg::COL_W'(1))) ? q_mid : l_ff;
      ev_right = fl_v_ff ? l_ff : q_mid;
      lap_full = $signed({5'b0, u_ff}) + $signed({5'b0, dn_ff})
               + $signed({5'b0, ev_left}) + $signed({5'b0, ev_right})
               - $signed({3'b0, c_ff, 2'b0});
      lap_sq   = lap_ff * lap_ff;
   end

   // Accumulate the sum and sum of squares
   always_ff @(posedge clock) begin
      lap_ff <= lap_full[bsfs_pkg::LAP_W-1:0];
      sq_ff  <= lap_sq[bsfs_pkg::SQ_W-1:0];
      if (reset) begin
         lap_v_ff <= 1'b0;
         sq_v_ff  <= 1'b0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
      end else begin
         lap_v_ff <= ev;
         sq_v_ff  <= lap_v_ff;
         if (cmd.restart || cmd.finish) begin
            sum_ff   <= '0;
            sqsum_ff <= '0;
         end else begin
            if (lap_v_ff) begin
               sum_ff <= sum_ff + bsfs_pkg::SUM_W'(lap_ff);
            end
            if (sq_v_ff) begin
               sqsum_ff <= sqsum_ff + bsfs_pkg::SQSUM_W'(sq_ff);
            end
         end
      end
   end

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         bsfs_pkg::MOP_N: begin
            mul_a = bsfs_pkg::OPND_W'(cfg.width);
            mul_b = bsfs_pkg::OPND_W'(cfg.height);
         end
         bsfs_pkg::MOP_SS_LL: begin
            mul_a = bsfs_pkg::OPND_W'(mag_ff[bsfs_pkg::HALF_W-1:0]);
            mul_b = bsfs_pkg::OPND_W'(mag_ff[bsfs_pkg::HALF_W-1:0]);
         end
         bsfs_pkg::MOP_SS_LH: begin
            mul_a = bsfs_pkg::OPND_W'(mag_ff[bsfs_pkg::HALF_W-1:0]);
            mul_b = bsfs_pkg::OPND_W'(mag_ff[bsfs_pkg::MAG_W-1:bsfs_pkg::HALF_W]);
         end
         bsfs_pkg::MOP_SS_HH: begin
            mul_a = bsfs_pkg::OPND_W'(mag_ff[bsfs_pkg::MAG_W-1:bsfs_pkg::HALF_W]);
            mul_b = bsfs_pkg::OPND_W'(mag_ff[bsfs_pkg::MAG_W-1:bsfs_pkg::HALF_W]);
         end
         bsfs_pkg::MOP_NQ_LO: begin
            mul_a = bsfs_pkg::OPND_W'(n_ff);
            mul_b = sqsum_ff[bsfs_pkg::OPND_W-1:0];
         end
         bsfs_pkg::MOP_NQ_HI: begin
            mul_a = bsfs_pkg::OPND_W'(n_ff);
            mul_b = bsfs_pkg::OPND_W'(sqsum_ff[bsfs_pkg::SQSUM_W-1:bsfs_pkg::OPND_W]);
         end
         bsfs_pkg::MOP_NN: begin
            mul_a = bsfs_pkg::OPND_W'(n_ff);
            mul_b = bsfs_pkg::OPND_W'(n_ff);
         end
         default: ;
      endcase
   end

   // Align the registered product to its weight
   always_comb begin
      case (prod_op_ff)
         bsfs_pkg::MOP_SS_LH: prod_sh = bsfs_pkg::WIDE_W'({prod_ff, 18'b0});
         bsfs_pkg::MOP_SS_HH: prod_sh = bsfs_pkg::WIDE_W'({prod_ff, 34'b0});
         bsfs_pkg::MOP_NQ_HI: prod_sh = bsfs_pkg::WIDE_W'({prod_ff, 24'b0});
         default:             prod_sh = bsfs_pkg::WIDE_W'(prod_ff);
      endcase
   end

   // Register the product, then accumulate it from the product register
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.mul_op == bsfs_pkg::MOP_N) begin
         mag_ff <= sum_ff[bsfs_pkg::SUM_W-1] ? bsfs_pkg::MAG_W'(-sum_ff)
                                             : bsfs_pkg::MAG_W'(sum_ff);
      end
      case (prod_op_ff)
         bsfs_pkg::MOP_N: begin
            n_ff  <= prod_ff[bsfs_pkg::N_W-1:0];
            nq_ff <= '0;
            ss_ff <= '0;
         end
         bsfs_pkg::MOP_SS_LL, bsfs_pkg::MOP_SS_LH, bsfs_pkg::MOP_SS_HH: begin
            ss_ff <= ss_ff + prod_sh;
         end
         bsfs_pkg::MOP_NQ_LO, bsfs_pkg::MOP_NQ_HI: begin
            nq_ff <= nq_ff + prod_sh;
         end
         bsfs_pkg::MOP_NN: begin
            den_ff <= prod_ff[bsfs_pkg::DEN_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_op_ff <= bsfs_pkg::MOP_NONE;
      end else begin
         prod_op_ff <= cmd.mul_op;
      end
   end

   // Restoring division, one quotient bit a cycle
   assign num   = {d_ff, {bsfs_pkg::FRAC_W{1'b0}}} + bsfs_pkg::NUM_W'(den_ff >> 1);
   assign trial = {rem_ff, qs_ff[bsfs_pkg::SCORE_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.sub_en) begin
         d_ff <= nq_ff - ss_ff;
      end
      if (cmd.load_en) begin
         rem_ff <= num[bsfs_pkg::SCORE_W +: bsfs_pkg::DEN_W];
         qs_ff  <= num[bsfs_pkg::SCORE_W-1:0];
      end else if (cmd.div_en) begin
         rem_ff <= ge ? bsfs_pkg::DEN_W'(trial - {1'b0, den_ff}) : trial[bsfs_pkg::DEN_W-1:0];
         qs_ff  <= {qs_ff[bsfs_pkg::SCORE_W-2:0], ge};
      end
   end

   // Track the first sharpest frame of the burst
   always_comb begin
      take    = (fib_ff == '0) || (d_ff > best_metric_ff);
      new_idx = take ? fib_ff : best_index_ff;
      new_var = take ? qs_ff : best_var_ff;
      done    = ({1'b0, fib_ff} + 1'b1) >= cfg.burst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fib_ff         <= '0;
         best_metric_ff <= '0;
         best_index_ff  <= '0;
         best_var_ff    <= '0;
      end else if (cmd.restart || (cmd.finish && done)) begin
         fib_ff         <= '0;
         best_metric_ff <= '0;
         best_index_ff  <= '0;
         best_var_ff    <= '0;
      end else if (cmd.finish) begin
         fib_ff         <= fib_ff + 1'b1;
         best_metric_ff <= take ? d_ff : best_metric_ff;
         best_index_ff  <= new_idx;
         best_var_ff    <= new_var;
      end
   end

   // Hold the result for transfer
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_frame_score    <= qs_ff;
         rsp_frame_number   <= fib_ff;
         rsp_burst_done     <= done;
         rsp_sharpest_frame <= done ? new_idx : '0;
         rsp_best_score     <= done ? new_var : '0;
      end
   end

endmodule

### tb/burst_sharpest_frame_select_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst sharpest-frame selector testbench
// Streams small gray and colour frames through the selector under random
// sender gaps and receiver stalls. A cycle-free model of the Laplacian
// variance and best-frame tracking predicts every frame result, and each
// result transfer is compared field by field against it.
// ----------------------------------------------------------------------------
module burst_sharpest_frame_select_top_test;

   localparam int IDLE_LIMIT = 60000;

   typedef struct {
      logic [bsfs_pkg::SCORE_W-1:0] score;
      logic [bsfs_pkg::IDX_W-1:0]   number;
      logic                         done;
      logic [bsfs_pkg::IDX_W-1:0]   best;
      logic [bsfs_pkg::SCORE_W-1:0] best_score;
   } frame_result_type;

   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [bsfs_pkg::CSR_IDX_W-1:0]  idx;
      logic [bsfs_pkg::CSR_DATA_W-1:0] data;
      logic [7:0]                      b, g, r;
      logic                            typed;
      frame_result_type                res;
   } stim_row_type;

   logic                            clock, reset;
   logic                            req_valid, req_ready;
   logic [bsfs_pkg::PIX_W-1:0]      req_blue_or_gray, req_green, req_red;
   logic                            rsp_valid, rsp_ready;
   logic [bsfs_pkg::SCORE_W-1:0]    rsp_frame_score, rsp_best_score;
   logic [bsfs_pkg::IDX_W-1:0]      rsp_frame_number, rsp_sharpest_frame;
   logic                            rsp_burst_done;
   logic                            csr_we;
   logic [bsfs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bsfs_pkg::CSR_DATA_W-1:0] csr_wdata;

   burst_sharpest_frame_select_top dut (.*);

   // Shadow configuration and frame state
   logic [bsfs_pkg::DIM_W-1:0]   cfg_width, cfg_height;
   logic [bsfs_pkg::BURST_W-1:0] cfg_burst;
   logic                         cfg_color;
   logic [7:0]                   line_up [bsfs_pkg::MAX_WIDTH];
   logic [7:0]                   line_mid [bsfs_pkg::MAX_WIDTH];
   logic [7:0]                   line_cur [bsfs_pkg::MAX_WIDTH];
   int                           col_pos, row_pos;
   logic signed [63:0]           lap_sum;
   logic [63:0]                  lap_sq_sum;
   int                           frame_idx, lead_idx;
   logic [127:0]                 best_numer;
   logic [bsfs_pkg::SCORE_W-1:0] best_var;

   frame_result_type pending_scores[$];
   int               err_count, pixel_count, frame_count, phase_count, idle_cycles;
   int               burst_left;
   bit               calm_sender;

   function automatic int eff_width();
      return cfg_width < 2 ? 2 : (cfg_width > bsfs_pkg::MAX_WIDTH ? bsfs_pkg::MAX_WIDTH
                                                                  : int'(cfg_width));
   endfunction

   function automatic int eff_height();
      return cfg_height < 2 ? 2 : (cfg_height > bsfs_pkg::MAX_HEIGHT ? bsfs_pkg::MAX_HEIGHT
                                                                     : int'(cfg_height));
   endfunction

   function automatic void restart_frame();
      col_pos = 0; row_pos = 0; lap_sum = 0; lap_sq_sum = 0;
      frame_idx = 0; lead_idx = 0; best_numer = 0; best_var = 0;
   endfunction

   // Add one row of Laplacian terms; up and down come from the current or upper line
   function automatic void sweep_row(bit up_cur, bit down_cur);
      int w, lft, rgt, up, dn, lap;
      w = eff_width();
      for (int c = 0; c < w; c++) begin
         lft = line_mid[c == 0 ? 1 : c - 1];
         rgt = line_mid[c == w - 1 ? w - 2 : c + 1];
         up  = up_cur ? line_cur[c] : line_up[c];
         dn  = down_cur ? line_cur[c] : line_up[c];
         lap = up + dn + lft + rgt - 4 * int'(line_mid[c]);
         lap_sum    += lap;
         lap_sq_sum += 64'(lap * lap);
      end
   endfunction

   function automatic void config_predict(logic [bsfs_pkg::CSR_IDX_W-1:0] idx,
                                          logic [bsfs_pkg::CSR_DATA_W-1:0] v);
      case (idx)
         bsfs_pkg::CSR_FRAME_WIDTH:  cfg_width  = v;
         bsfs_pkg::CSR_FRAME_HEIGHT: cfg_height = v;
         bsfs_pkg::CSR_BURST_LENGTH: cfg_burst  = v[bsfs_pkg::BURST_W-1:0];
         bsfs_pkg::CSR_COLOR_INPUT:  cfg_color  = v[0];
         default: ;
      endcase
      restart_frame();
   endfunction

   // Advance the frame by one pixel; return 1 with the result at frame end
   function automatic bit sharpness_predict(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                            output frame_result_type res);
      int           w, h, eb;
      logic [7:0]   gray;
      logic [63:0]  n, mag;
      logic [127:0] numer, nn;
      logic [135:0] q;
      bit           done;
      w  = eff_width();
      h  = eff_height();
      eb = cfg_burst < 1 ? 1 : (cfg_burst > bsfs_pkg::MAX_BURST ? bsfs_pkg::MAX_BURST
                                                                : int'(cfg_burst));
      if (cfg_color)
         gray = 8'((32'd1868 * b + 32'd9617 * g + 32'd4899 * r + 32'd8192) >> 14);
      else
         gray = b;
      if (col_pos >= w) col_pos = 0;
      line_cur[col_pos] = gray;
      col_pos++;
      if (col_pos < w) return 0;
      col_pos = 0;
      if (row_pos >= 1) sweep_row(row_pos == 1, 1'b1);
      for (int c = 0; c < w; c++) begin
         line_up[c]  = line_mid[c];
         line_mid[c] = line_cur[c];
      end
      row_pos++;
      if (row_pos < h) return 0;
      // bottom border reflects onto the row above
      sweep_row(1'b0, 1'b0);
      row_pos = 0;
      n     = 64'(w) * 64'(h);
      mag   = lap_sum < 0 ? 64'(-lap_sum) : 64'(lap_sum);
      numer = 128'(n) * 128'(lap_sq_sum) - 128'(mag) * 128'(mag);
      nn    = 128'(n) * 128'(n);
      q     = ((136'(numer) << 8) + 136'(nn >> 1)) / 136'(nn);
      lap_sum = 0; lap_sq_sum = 0;
      if (frame_idx == 0 || numer > best_numer) begin
         best_numer = numer;
         lead_idx   = frame_idx;
         best_var   = q[bsfs_pkg::SCORE_W-1:0];
      end
      done = frame_idx + 1 >= eb;
      res.score      = q[bsfs_pkg::SCORE_W-1:0];
      res.number     = bsfs_pkg::IDX_W'(frame_idx);
      res.done       = done;
      res.best       = done ? bsfs_pkg::IDX_W'(lead_idx) : '0;
      res.best_score = done ? best_var : '0;
      if (done) begin
         frame_idx = 0; lead_idx = 0; best_numer = 0; best_var = 0;
      end else begin
         frame_idx++;
      end
      return 1;
   endfunction

   function automatic void compare_result(frame_result_type e, frame_result_type a);
      if (a.score !== e.score) begin
         $error("frame_score expected %0d got %0d", e.score, a.score); err_count++;
      end
      if (a.number !== e.number) begin
         $error("frame_number expected %0d got %0d", e.number, a.number); err_count++;
      end
      if (a.done !== e.done) begin
         $error("burst_done expected %0d got %0d", e.done, a.done); err_count++;
      end
      if (a.best !== e.best) begin
         $error("sharpest_frame expected %0d got %0d", e.best, a.best); err_count++;
      end
      if (a.best_score !== e.best_score) begin
         $error("best_score expected %0d got %0d", e.best_score, a.best_score); err_count++;
      end
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver stall pattern: full speed, coin flips, or long holds
   int stall_mode, stall_tick;
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= (stall_tick % 16) > 11;
      endcase
   end

   // Check result transfers and watch for a hang
   always @(posedge clock) begin
      frame_result_type act, exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         act.score = rsp_frame_score; act.number = rsp_frame_number;
         act.done = rsp_burst_done; act.best = rsp_sharpest_frame;
         act.best_score = rsp_best_score;
         if (pending_scores.size() == 0) begin
            $error("result transfer with no frame expected"); err_count++;
         end else begin
            exp_res = pending_scores.pop_front();
            compare_result(exp_res, act);
            frame_count++;
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Wait for outstanding frames, then for any row sweep to settle
   task automatic wait_idle();
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (eff_width() + 64) @(posedge clock);
   endtask

   task automatic write_reg(logic [bsfs_pkg::CSR_IDX_W-1:0] idx,
                            logic [bsfs_pkg::CSR_DATA_W-1:0] v);
      req_valid <= 1'b0;
      wait_idle();
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      config_predict(idx, v);
      @(posedge clock);
   endtask

   // Send one pixel; typed results are checked against the model first
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             bit typed, frame_result_type typed_res);
      int               gap;
      frame_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = calm_sender ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_blue_or_gray <= b; req_green <= g; req_red <= r;
      do @(posedge clock); while (!req_ready);
      pixel_count++;
      if (sharpness_predict(b, g, r, res)) begin
         if (typed) compare_result(typed_res, res);
         pending_scores.insert(pending_scores.size(), res);
      end
   endtask

   // Directed table: flat frame, full-swing checkerboard, colour extremes, clamps
   localparam frame_result_type NO_RES = '{0, 0, 0, 0, 0};
   stim_row_type directed_tbl [25] = '{
      '{ROW_CSR, bsfs_pkg::CSR_FRAME_WIDTH,  12'd2, 0, 0, 0, 0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_FRAME_HEIGHT, 12'd2, 0, 0, 0, 0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_BURST_LENGTH, 12'd1, 0, 0, 0, 0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_COLOR_INPUT,  12'd0, 0, 0, 0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0, 8'd0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0, 8'd0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0, 8'd0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0, 8'd0, 1, '{0, 0, 1, 0, 0}},
      '{ROW_PIX, 0, 0, 8'd255, 8'd0, 8'd0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0, 8'd0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0, 8'd0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd255, 8'd0, 8'd0, 1, '{266342400, 0, 1, 0, 266342400}},
      '{ROW_CSR, bsfs_pkg::CSR_COLOR_INPUT,  12'd1, 0, 0, 0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd255, 8'd0,   8'd0,   0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd255, 8'd0,   0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0,   8'd255, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd255, 8'd255, 8'd255, 0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_BURST_LENGTH, 12'd31, 0, 0, 0, 0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_FRAME_WIDTH,  12'd0,  0, 0, 0, 0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_FRAME_HEIGHT, 12'd1,  0, 0, 0, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0,   8'd0,   0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd255, 8'd255, 8'd255, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd255, 8'd255, 8'd255, 0, NO_RES},
      '{ROW_PIX, 0, 0, 8'd0,   8'd0,   8'd0,   0, NO_RES},
      '{ROW_CSR, bsfs_pkg::CSR_BURST_LENGTH, 12'd0,  0, 0, 0, 0, NO_RES}
   };

   // Stimulus
   initial begin
      int               frames, w, h, pix_style, npix;
      logic [7:0]       b, g, r;
      frame_result_type none;
      reset = 1'b1; req_valid = 1'b0; rsp_ready = 1'b0; csr_we = 1'b0;
      csr_index = '0; csr_wdata = '0;
      req_blue_or_gray = '0; req_green = '0; req_red = '0;
      stall_mode = 0; stall_tick = 0; burst_left = 0; calm_sender = 0;
      err_count = 0; pixel_count = 0; frame_count = 0; phase_count = 0; idle_cycles = 0;
      cfg_width = bsfs_pkg::RST_FRAME_WIDTH; cfg_height = bsfs_pkg::RST_FRAME_HEIGHT;
      cfg_burst = bsfs_pkg::RST_BURST_LENGTH; cfg_color = bsfs_pkg::RST_COLOR_INPUT;
      for (int i = 0; i < bsfs_pkg::MAX_WIDTH; i++) begin
         line_up[i] = 0; line_mid[i] = 0; line_cur[i] = 0;
      end
      restart_frame();
      none = NO_RES;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_tbl[i]) begin
         if (directed_tbl[i].kind == ROW_CSR)
            write_reg(directed_tbl[i].idx, directed_tbl[i].data);
         else
            send_pixel(directed_tbl[i].b, directed_tbl[i].g, directed_tbl[i].r,
                       directed_tbl[i].typed, directed_tbl[i].res);
      end
      req_valid <= 1'b0;

      // Random phases: small frames with occasional clamped sizes
      while (pixel_count < 800) begin
         phase_count++;
         calm_sender = ($urandom_range(0, 3) == 0);
         w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 9);
         h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 5);
         write_reg(bsfs_pkg::CSR_COLOR_INPUT, 12'($urandom_range(0, 1)));
         write_reg(bsfs_pkg::CSR_BURST_LENGTH,
                   12'($urandom_range(0, 9) == 0 ? $urandom_range(16, 31)
                                                 : $urandom_range(0, 6)));
         write_reg(bsfs_pkg::CSR_FRAME_WIDTH, 12'(w));
         write_reg(bsfs_pkg::CSR_FRAME_HEIGHT, 12'(h));
         frames = (w > 9 || h > 9) ? 1 : $urandom_range(1, 8);
         for (int f = 0; f < frames; f++) begin
            pix_style = $urandom_range(0, 3);
            for (int p = 0; p < eff_width() * eff_height(); p++) begin
               case (pix_style)
                  0: begin b = $urandom; g = $urandom; r = $urandom; end
                  1: begin
                     b = $urandom_range(0, 1) ? 8'hFF : 8'h00; g = b; r = b;
                  end
                  2: begin b = 8'd128; g = 8'd128; r = 8'd128; end
                  default: begin
                     b = 8'($urandom_range(120, 136)); g = $urandom; r = $urandom;
                  end
               endcase
               send_pixel(b, g, r, 1'b0, none);
            end
         end
         // sometimes leave a partial frame behind before the next setting
         if ($urandom_range(0, 2) == 0) begin
            npix = $urandom_range(1, 2 * eff_width());
            for (int p = 0; p < npix; p++) send_pixel($urandom, $urandom, $urandom, 1'b0, none);
         end
         req_valid <= 1'b0;
      end

      while (pending_scores.size() != 0) @(posedge clock);
      repeat (2200) @(posedge clock);
      $display("Sent %0d pixels over %0d setting phases; checked %0d frame results.",
               pixel_count, phase_count, frame_count);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/bsfs_pkg.sv
hw/rtl/bsfs_ctrl.sv
hw/rtl/bsfs_datapath.sv
hw/rtl/burst_sharpest_frame_select_top.sv
tb/burst_sharpest_frame_select_top_test.sv
